// ===== rtl/kvm_pkg.sv =====
// Shared types, codes and preload table of the key/value mailbox controller.
package kvm_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_IDXRD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        H_PLAIN  = 2'd0,
        H_COUNT  = 2'd1,
        H_POWER  = 2'd2,
        H_NOTIFY = 2'd3
    } t_handler;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  size;
        logic [31:0] kind;
        logic [7:0]  attr;
        logic [63:0] value;
        t_handler    handler;
    } t_entry;

    localparam logic [7:0] FUNC_READ     = 8'h10;
    localparam logic [7:0] FUNC_READ_ALT = 8'h20;
    localparam logic [7:0] FUNC_WRITE    = 8'h11;
    localparam logic [7:0] FUNC_BY_INDEX = 8'h12;
    localparam logic [7:0] FUNC_INFO     = 8'h13;
    localparam logic [7:0] FUNC_BUF_ADDR = 8'h17;

    localparam logic [7:0] ST_OK         = 8'h00;
    localparam logic [7:0] ST_BAD_CMD    = 8'h82;
    localparam logic [7:0] ST_NOT_FOUND  = 8'h84;
    localparam logic [7:0] ST_NO_READ    = 8'h85;
    localparam logic [7:0] ST_NO_WRITE   = 8'h86;
    localparam logic [7:0] ST_BAD_ARG    = 8'h89;
    localparam logic [7:0] ST_BAD_INDEX  = 8'hB8;
    localparam logic [7:0] ST_BAD_POWER  = 8'hC0;
    localparam logic [7:0] ST_NOTE       = 8'h18;

    localparam logic [7:0] NOTE_PANB     = 8'h22;
    localparam logic [7:0] NOTE_PANE     = 8'h0A;
    localparam logic [7:0] NOTE_ENDPOINT = 8'h70;

    localparam logic [31:0] PW_OFFW = 32'h6F666677;
    localparam logic [31:0] PW_OFF1 = 32'h6F666631;
    localparam logic [31:0] PW_SUSP = 32'h73757370;
    localparam logic [31:0] PW_REST = 32'h72657374;
    localparam logic [31:0] PW_SLPW = 32'h736C7077;
    localparam logic [31:0] PW_PANB = 32'h70616E62;
    localparam logic [31:0] PW_PANE = 32'h70616E65;

    localparam logic [7:0] PRELOAD_COUNT = 8'd6;
    localparam logic [7:0] PRELOAD_ATTR  = 8'h04;

    // All-ones in the low n bytes.
    function automatic logic [63:0] byte_mask(input logic [7:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (n > 8'(b)) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Reset contents of one table entry.
    function automatic t_entry preload(input logic [7:0] idx);
        t_entry e;
        e = '0;
        unique case (idx)
            8'd0: e = '{32'h234B4559, 8'd4, 32'h75693332, PRELOAD_ATTR, 64'd0, H_COUNT};
            8'd1: e = '{32'h434C4B48, 8'd8, 32'h7B636C68, PRELOAD_ATTR,
                        64'h4019010080700000, H_PLAIN};
            8'd2: e = '{32'h5247454E, 8'd1, 32'h75693820, PRELOAD_ATTR, 64'd3, H_PLAIN};
            8'd3: e = '{32'h61444323, 8'd4, 32'h75693332, PRELOAD_ATTR, 64'd0, H_PLAIN};
            8'd4: e = '{32'h4D425345, 8'd4, 32'h6865785F, PRELOAD_ATTR, 64'd0, H_POWER};
            8'd5: e = '{32'h4E45534E, 8'd4, 32'h6865785F, PRELOAD_ATTR, 64'd0, H_NOTIFY};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/kvm_cmd_if.sv =====
// Command channel: one mailbox command per transfer.
interface kvm_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  func;
    logic [7:0]  tag;
    logic [7:0]  length;
    logic [31:0] key_name;
    logic [63:0] write_data;

    modport source (output valid, func, tag, length, key_name, write_data, input ready);
    modport sink   (input valid, func, tag, length, key_name, write_data, output ready);
endinterface

// ===== rtl/kvm_rsp_if.sv =====
// Response channel: one result word and its side flags per transfer.
interface kvm_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] message;
    logic [63:0] buffer_data;
    logic        buffer_write;
    logic        shutdown_request;
    logic        table_full;
    logic        value_truncated;
    logic        last;

    modport source (output valid, message, buffer_data, buffer_write, shutdown_request,
                    table_full, value_truncated, last, input ready);
    modport sink   (input valid, message, buffer_data, buffer_write, shutdown_request,
                    table_full, value_truncated, last, output ready);
endinterface

// ===== rtl/kvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/key_value_mailbox_controller.sv =====
// Top level of the key/value mailbox controller: sequencer over the key table RAM.
//
// One command is taken at a time. A command that names a key (read, write,
// info) scans the table from entry 0, one RAM read a cycle with the compare on
// the registered read data. A match ends the scan early. By-index needs one
// table read, or none when the index is out of range; buffer-address and
// unknown commands go straight to the response. A power write of a panic word
// gives two transfers, the notification (last low) and then the response. The
// response register lets the next command enter while a result still waits;
// a second result that finds the register still full holds the sequencer, and
// with it the input. The table lives in one RAM; per-entry valid bits, cleared
// at reset, make an entry never written read as its preloaded contents, so no
// clearing pass is needed.
// Write the configuration register only while no command is in flight: the
// buffer address is read when the response is formed.
module key_value_mailbox_controller #(
    parameter int MAX_KEYS    = 16,
    parameter int VALUE_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    kvm_cmd_if.sink     i_cmd,
    kvm_rsp_if.source   o_rsp
);
    import kvm_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int TW = $clog2(MAX_KEYS + 1);
    localparam int VW = 8 * VALUE_BYTES;
    localparam int RW = 32 + 8 + 32 + 8 + VW + 2;
    localparam logic [TW-1:0] TOTAL_MAX = TW'(MAX_KEYS);
    localparam logic [7:0]    VB8       = 8'(VALUE_BYTES);

    t_state r_state, n_state;

    // command held for the whole transaction
    logic [7:0]  r_func, r_tag, r_len;
    logic [31:0] r_key;
    logic [63:0] r_wdata;

    logic [TW-1:0] r_idx, r_total;
    logic          r_pend, r_rdv, r_found, r_note;
    logic [AW-1:0] r_pidx, r_fidx;
    logic [MAX_KEYS-1:0] r_valid;
    logic [63:0]   r_buf_addr;

    // captured entry
    logic [31:0] r_eid, r_ekind;
    logic [7:0]  r_esize, r_eattr;
    logic [VW-1:0] r_evalue;
    t_handler    r_ehand;

    // response register
    logic        r_ov;
    logic [63:0] r_msg, r_buf;
    logic        r_bw, r_sd, r_full, r_trunc, r_last;

    logic [AW-1:0] rd_addr, wr_addr;
    logic [RW-1:0] rd_data, wr_data;
    logic          wr_en;

    logic accept, ofree, issue, match, idx_ok;
    logic [31:0] e_id, e_kind;
    logic [7:0]  e_size, e_attr;
    logic [VW-1:0] e_value;
    t_handler    e_hand;
    t_entry      pre;

    logic        c_emit, c_done;
    logic [63:0] c_msg, c_buf;
    logic        c_bw, c_sd, c_full, c_trunc, c_last;
    logic [VW-1:0] c_wval;
    logic [7:0]  c_kept;

    kvm_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign accept = i_cmd.valid && i_cmd.ready;
    assign ofree  = !r_ov || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign idx_ok = ({{(32-TW){1'b0}}, r_total} > i_cmd.key_name);
    assign issue  = (r_idx < r_total);

    // read address: scan pointer, or the index straight from the command
    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_IDLE) begin
            rd_addr = i_cmd.key_name[AW-1:0];
        end
    end

    // entry as read, or its preload when never written
    always_comb begin
        pre = preload(8'(r_pidx));
        if (r_rdv) begin
            {e_id, e_size, e_kind, e_attr, e_value} = rd_data[RW-1:2];
            e_hand = t_handler'(rd_data[1:0]);
        end else begin
            e_id    = pre.id;
            e_size  = pre.size;
            e_kind  = pre.kind;
            e_attr  = pre.attr;
            e_value = pre.value[VW-1:0] & VW'(byte_mask((pre.size < VB8) ? pre.size : VB8));
            e_hand  = pre.handler;
        end
    end

    assign match = r_pend && (e_id == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.func) inside
                        FUNC_READ, FUNC_READ_ALT, FUNC_WRITE, FUNC_INFO: n_state = S_SCAN;
                        FUNC_BY_INDEX: n_state = idx_ok ? S_IDXRD : S_EMIT;
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_SCAN:  if (match || !issue) n_state = S_EMIT;
            S_IDXRD: n_state = S_EMIT;
            S_EMIT:  if (c_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // response composition and table write-back
    always_comb begin
        c_emit  = (r_state == S_EMIT) && ofree;
        c_done  = c_emit;
        c_msg   = '0;
        c_buf   = '0;
        c_bw    = 1'b0;
        c_sd    = 1'b0;
        c_full  = 1'b0;
        c_trunc = 1'b0;
        c_last  = 1'b1;
        wr_en   = 1'b0;
        wr_addr = r_fidx;
        c_kept  = (r_len < VB8) ? r_len : VB8;
        c_wval  = r_wdata[VW-1:0] & VW'(byte_mask(c_kept));
        wr_data = {r_eid, r_len, r_ekind, r_eattr, c_wval, r_ehand};
        case (r_func) inside
            FUNC_BUF_ADDR: c_msg = r_buf_addr;
            FUNC_READ, FUNC_READ_ALT: begin
                logic [7:0]    sz;
                logic [VW-1:0] val;
                sz  = (r_ehand == H_COUNT) ? 8'd4 : r_esize;
                val = (r_ehand == H_COUNT) ? VW'(r_total) : r_evalue;
                if (!r_found) begin
                    c_msg = {48'd0, r_tag, ST_NOT_FOUND};
                end else if (r_ehand == H_POWER || r_ehand == H_NOTIFY) begin
                    c_msg = {48'd0, r_tag, ST_NO_READ};
                end else if (sz <= 8'd4) begin
                    c_msg = {val[31:0] & 32'(byte_mask(sz)), 8'd0, sz, r_tag, ST_OK};
                end else begin
                    c_msg = {32'd0, 8'd0, sz, r_tag, ST_OK};
                    c_buf = 64'(val & VW'(byte_mask((sz < VB8) ? sz : VB8)));
                    c_bw  = 1'b1;
                end
            end
            FUNC_WRITE: begin
                logic [7:0] st;
                st = ST_OK;
                if (r_found && r_ehand == H_COUNT) begin
                    st = ST_NO_WRITE;
                end else if (r_found && r_ehand == H_POWER) begin
                    if (r_len != r_esize) begin
                        st = ST_BAD_ARG;
                    end else begin
                        case (r_wdata[31:0]) inside
                            PW_OFFW, PW_OFF1, PW_SUSP: c_sd = 1'b1;
                            PW_REST, PW_SLPW: st = ST_OK;
                            PW_PANB, PW_PANE: begin
                                // send the notification ahead of the response
                                if (!r_note) begin
                                    c_done = 1'b0;
                                    c_last = 1'b0;
                                end
                            end
                            default: st = ST_BAD_POWER;
                        endcase
                    end
                end else begin
                    c_trunc = (r_len > VB8);
                    if (r_found) begin
                        wr_en = c_done;
                    end else if (r_total >= TOTAL_MAX) begin
                        c_full = 1'b1;
                    end else begin
                        wr_en   = c_done;
                        wr_addr = r_total[AW-1:0];
                        wr_data = {r_key, r_len, 32'd0, 8'd0, c_wval, H_PLAIN};
                    end
                end
                if (!c_last) begin
                    c_msg = {NOTE_ENDPOINT,
                             (r_wdata[31:0] == PW_PANB) ? NOTE_PANB : NOTE_PANE,
                             40'd0, ST_NOTE};
                    c_sd  = 1'b0;
                end else begin
                    c_msg = {40'd0, r_len, r_tag, st};
                end
            end
            FUNC_BY_INDEX: begin
                if (r_found) begin
                    c_msg = {r_eid[7:0], r_eid[15:8], r_eid[23:16], r_eid[31:24],
                             16'd0, r_tag, ST_OK};
                end else begin
                    c_msg = {48'd0, r_tag, ST_BAD_INDEX};
                end
            end
            FUNC_INFO: begin
                if (r_found) begin
                    c_msg = {48'd0, r_tag, ST_OK};
                    c_buf = {16'd0, r_eattr, r_ekind, r_esize};
                    c_bw  = 1'b1;
                end else begin
                    c_msg = {48'd0, r_tag, ST_NOT_FOUND};
                end
            end
            default: c_msg = {48'd0, r_tag, ST_BAD_CMD};
        endcase
    end

    always_ff @(posedge i_clk) begin
        // track which entry the registered read data belongs to
        r_pidx <= rd_addr;
        r_rdv  <= r_valid[rd_addr];

        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= TW'(PRELOAD_COUNT);
            r_valid    <= '0;
            r_buf_addr <= '0;
            r_ov       <= 1'b0;
            r_pend     <= 1'b0;
            r_note     <= 1'b0;
            r_found    <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_buf_addr <= i_cfg_data;
            end

            if (accept) begin
                r_func  <= i_cmd.func;
                r_tag   <= i_cmd.tag;
                r_len   <= i_cmd.length;
                r_key   <= i_cmd.key_name;
                r_wdata <= i_cmd.write_data;
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_note  <= 1'b0;
                r_found <= (i_cmd.func == FUNC_BY_INDEX) && idx_ok;
            end

            // advance the scan; hold the matching entry
            if (r_state == S_SCAN) begin
                if (match) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_pidx;
                end else if (issue) begin
                    r_pend <= 1'b1;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            if ((r_state == S_SCAN && match) || r_state == S_IDXRD) begin
                r_eid    <= e_id;
                r_esize  <= e_size;
                r_ekind  <= e_kind;
                r_eattr  <= e_attr;
                r_evalue <= e_value;
                r_ehand  <= e_hand;
            end

            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
                if (!r_found) begin
                    r_total <= r_total + 1'b1;
                end
            end

            // response register
            if (c_emit) begin
                r_ov    <= 1'b1;
                r_msg   <= c_msg;
                r_buf   <= c_buf;
                r_bw    <= c_bw;
                r_sd    <= c_sd;
                r_full  <= c_full;
                r_trunc <= c_trunc;
                r_last  <= c_last;
                if (!c_last) begin
                    r_note <= 1'b1;
                end
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_rsp.valid            = r_ov;
    assign o_rsp.message          = r_msg;
    assign o_rsp.buffer_data      = r_buf;
    assign o_rsp.buffer_write     = r_bw;
    assign o_rsp.shutdown_request = r_sd;
    assign o_rsp.table_full       = r_full;
    assign o_rsp.value_truncated  = r_trunc;
    assign o_rsp.last             = r_last;

    a_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_EMIT && r_func == FUNC_WRITE))
        else $error("table written outside a write response");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOTAL_MAX)
        else $error("key total beyond table depth");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !r_found) |=> (r_total == $past(r_total) + 1'b1))
        else $error("appended key not counted");

    a_note_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_emit && !c_last) |=> (r_state == S_EMIT && r_note))
        else $error("notification not followed by its response");
endmodule

// ===== dv/kvm_checker.sv =====
// Checker for the key/value mailbox controller: predicts responses and compares them.
module kvm_checker #(
    parameter int MAX_KEYS    = 16,
    parameter int VALUE_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    kvm_cmd_if          i_cmd,
    kvm_rsp_if          i_rsp,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import kvm_pkg::*;

    typedef struct packed {
        logic [63:0] message;
        logic [63:0] buffer_data;
        logic        buffer_write;
        logic        shutdown_request;
        logic        table_full;
        logic        value_truncated;
        logic        last;
    } t_result;

    logic [63:0] buf_addr;
    logic [31:0] tbl_id    [MAX_KEYS];
    logic [7:0]  tbl_size  [MAX_KEYS];
    logic [31:0] tbl_kind  [MAX_KEYS];
    logic [7:0]  tbl_attr  [MAX_KEYS];
    logic [63:0] tbl_value [MAX_KEYS];
    t_handler    tbl_hdl   [MAX_KEYS];
    int          num_keys;
    t_result     awaited_results[$];

    function automatic logic [63:0] low_bytes(input int n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int lookup_key(input logic [31:0] id);
        for (int k = 0; k < num_keys; k++)
            if (tbl_id[k] == id) return k;
        return -1;
    endfunction

    task automatic reset_table();
        for (int k = 0; k < MAX_KEYS; k++) begin
            tbl_id[k] = '0; tbl_size[k] = '0; tbl_kind[k] = '0;
            tbl_attr[k] = '0; tbl_value[k] = '0; tbl_hdl[k] = H_PLAIN;
        end
        tbl_id[0] = 32'h234B4559; tbl_size[0] = 4; tbl_kind[0] = 32'h75693332;
        tbl_hdl[0] = H_COUNT;
        tbl_id[1] = 32'h434C4B48; tbl_size[1] = 8; tbl_kind[1] = 32'h7B636C68;
        tbl_value[1] = 64'h4019010080700000;
        tbl_id[2] = 32'h5247454E; tbl_size[2] = 1; tbl_kind[2] = 32'h75693820;
        tbl_value[2] = 64'd3;
        tbl_id[3] = 32'h61444323; tbl_size[3] = 4; tbl_kind[3] = 32'h75693332;
        tbl_id[4] = 32'h4D425345; tbl_size[4] = 4; tbl_kind[4] = 32'h6865785F;
        tbl_hdl[4] = H_POWER;
        tbl_id[5] = 32'h4E45534E; tbl_size[5] = 4; tbl_kind[5] = 32'h6865785F;
        tbl_hdl[5] = H_NOTIFY;
        for (int k = 0; k < 6; k++) tbl_attr[k] = 8'h04;
        num_keys = 6;
        buf_addr = '0;
    endtask

    // Work out the results of one command and queue them.
    task automatic predict_command(input logic [7:0] func, input logic [7:0] tag,
                                   input logic [7:0] len, input logic [31:0] key,
                                   input logic [63:0] wdata);
        t_result r;
        int      k;
        int      sz;
        logic [7:0] st;
        logic [7:0] note;
        r = '0;
        r.last = 1'b1;
        r.message[15:8] = tag;
        case (func) inside
            FUNC_BUF_ADDR: r.message = buf_addr;
            FUNC_READ, FUNC_READ_ALT: begin
                k = lookup_key(key);
                if (k < 0) r.message[7:0] = ST_NOT_FOUND;
                else if (tbl_hdl[k] == H_POWER || tbl_hdl[k] == H_NOTIFY)
                    r.message[7:0] = ST_NO_READ;
                else begin
                    if (tbl_hdl[k] == H_COUNT) begin
                        tbl_size[k] = 4;
                        tbl_value[k] = 64'(num_keys);
                    end
                    sz = int'(tbl_size[k]);
                    r.message[23:16] = tbl_size[k];
                    if (sz <= 4) r.message[63:32] = 32'(tbl_value[k] & low_bytes(sz));
                    else begin
                        r.buffer_data  = tbl_value[k] & low_bytes(sz < VALUE_BYTES ?
                                                                  sz : VALUE_BYTES);
                        r.buffer_write = 1'b1;
                    end
                end
            end
            FUNC_WRITE: begin
                st = ST_OK;
                note = '0;
                k = lookup_key(key);
                r.message[23:16] = len;
                if (k >= 0 && tbl_hdl[k] == H_COUNT) st = ST_NO_WRITE;
                else if (k >= 0 && tbl_hdl[k] == H_POWER) begin
                    if (len != tbl_size[k]) st = ST_BAD_ARG;
                    else case (wdata[31:0]) inside
                        PW_OFFW, PW_OFF1, PW_SUSP: r.shutdown_request = 1'b1;
                        PW_REST, PW_SLPW: ;
                        PW_PANB: note = NOTE_PANB;
                        PW_PANE: note = NOTE_PANE;
                        default: st = ST_BAD_POWER;
                    endcase
                end else begin
                    if (k < 0) begin
                        if (num_keys >= MAX_KEYS) r.table_full = 1'b1;
                        else begin
                            k = num_keys;
                            tbl_id[k] = key; tbl_kind[k] = '0; tbl_attr[k] = '0;
                            tbl_hdl[k] = H_PLAIN;
                            num_keys++;
                        end
                    end
                    if (k >= 0) begin
                        tbl_size[k]  = len;
                        tbl_value[k] = wdata & low_bytes(len < VALUE_BYTES ?
                                                         len : VALUE_BYTES);
                    end
                    r.value_truncated = (len > VALUE_BYTES);
                end
                if (note != '0) begin
                    t_result n;
                    n = '0;
                    n.message[7:0]   = ST_NOTE;
                    n.message[55:48] = note;
                    n.message[63:56] = NOTE_ENDPOINT;
                    awaited_results.push_back(n);
                end
                r.message[7:0] = st;
            end
            FUNC_BY_INDEX: begin
                if (key < num_keys) begin
                    r.message[39:32] = tbl_id[key][31:24];
                    r.message[47:40] = tbl_id[key][23:16];
                    r.message[55:48] = tbl_id[key][15:8];
                    r.message[63:56] = tbl_id[key][7:0];
                end else r.message[7:0] = ST_BAD_INDEX;
            end
            FUNC_INFO: begin
                k = lookup_key(key);
                if (k < 0) r.message[7:0] = ST_NOT_FOUND;
                else begin
                    r.buffer_data  = {16'd0, tbl_attr[k], tbl_kind[k], tbl_size[k]};
                    r.buffer_write = 1'b1;
                end
            end
            default: r.message[7:0] = ST_BAD_CMD;
        endcase
        awaited_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        o_errors++;
        if (o_errors <= 10)
            $display("MISMATCH %s: expected msg=%h buf=%h bw%b sd%b full%b trunc%b last%b,",
                     what, want.message, want.buffer_data, want.buffer_write,
                     want.shutdown_request, want.table_full, want.value_truncated,
                     want.last,
                     " got msg=%h buf=%h bw%b sd%b full%b trunc%b last%b",
                     got.message, got.buffer_data, got.buffer_write,
                     got.shutdown_request, got.table_full, got.value_truncated,
                     got.last);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            reset_table();
            awaited_results.delete();
            o_errors  = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) buf_addr = i_cfg_data;
            if (i_cmd.valid && i_cmd.ready)
                predict_command(i_cmd.func, i_cmd.tag, i_cmd.length, i_cmd.key_name,
                                i_cmd.write_data);
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.message, i_rsp.buffer_data, i_rsp.buffer_write,
                        i_rsp.shutdown_request, i_rsp.table_full, i_rsp.value_truncated,
                        i_rsp.last};
                o_results = o_results + 1;
                if (awaited_results.size() == 0) report_mismatch("unexpected", '0, got);
                else begin
                    want = awaited_results.pop_front();
                    if (got !== want) report_mismatch("field", want, got);
                end
            end
        end
        o_pending = awaited_results.size();
    end
endmodule

// ===== dv/testbench.sv =====
// Top of the mailbox controller testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kvm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_data;
    int          errors;
    int          pending;
    int          results;
    int          cycles;
    int          sent;
    bit          quiet_tail;  // no idling in the closing stretch
    bit          hold_off;    // long receiver stall, requested by the stimulus

    kvm_cmd_if cmd ();
    kvm_rsp_if rsp ();

    key_value_mailbox_controller uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd.sink),
        .o_rsp     (rsp.source)
    );

    kvm_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd),
        .i_rsp     (rsp),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycles);
                $display("key_value_mailbox_controller regression: fail");
                $finish;
            end
        end
    end

    // Receiver: ready drops in short random bursts, or for one long stretch
    // once hold_off is raised so that the block fills and stalls its input.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !held) begin
                held = 1'b1;
                rsp.ready = 1'b0;
                repeat (60) @(negedge i_clk);
                rsp.ready = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 4);
                rsp.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                rsp.ready = 1'b1;
            end
        end
    end

    // Offer one command and hold it until the transfer, with an optional
    // idle burst beforehand.
    task automatic send_command(input logic [7:0] func, input logic [7:0] tag,
                                input logic [7:0] len, input logic [31:0] key,
                                input logic [63:0] wdata);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            cmd.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        cmd.valid      = 1'b1;
        cmd.func       = func;
        cmd.tag        = tag;
        cmd.length     = len;
        cmd.key_name   = key;
        cmd.write_data = wdata;
        do @(posedge i_clk); while (!cmd.ready);
        @(negedge i_clk);
        cmd.valid = 1'b0;
        sent++;
    endtask

    // Drain outstanding results, let the block settle, write the register, then read it back.
    task automatic write_buffer_address(input logic [63:0] value);
        cmd.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        send_command(FUNC_BUF_ADDR, 8'($urandom), 8'($urandom), $urandom,
                     {$urandom, $urandom});
    endtask

    function automatic logic [31:0] pick_key(input int new_keys);
        logic [31:0] known [9];
        known = '{32'h234B4559, 32'h434C4B48, 32'h5247454E, 32'h61444323, 32'h4D425345,
                  32'h4E45534E, 32'h41414141, 32'h42424242, 32'hFFFFFFFF};
        if ($urandom_range(0, 9) < new_keys) return $urandom;
        return known[$urandom_range(0, 8)];
    endfunction

    function automatic logic [31:0] power_word();
        logic [31:0] w [8];
        w = '{PW_OFFW, PW_OFF1, PW_SUSP, PW_REST, PW_SLPW, PW_PANB, PW_PANE, 32'h0};
        return $urandom_range(0, 9) < 8 ? w[$urandom_range(0, 6)] : $urandom;
    endfunction

    // One random command, mostly well-formed operations on known keys.
    task automatic random_command(input int new_keys);
        logic [7:0]  func;
        logic [7:0]  len;
        logic [31:0] key;
        logic [63:0] wdata;
        logic [7:0]  funcs [7];
        funcs = '{FUNC_READ, FUNC_READ_ALT, FUNC_WRITE, FUNC_BY_INDEX, FUNC_INFO,
                  FUNC_BUF_ADDR, FUNC_WRITE};
        func  = ($urandom_range(0, 19) == 0) ? 8'($urandom) : funcs[$urandom_range(0, 6)];
        key   = pick_key(new_keys);
        wdata = {$urandom, $urandom};
        len   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        if (func == FUNC_BY_INDEX) key = $urandom_range(0, 3) == 0 ? $urandom
                                                               : $urandom_range(0, 17);
        if (func == FUNC_WRITE && key == 32'h4D425345) begin
            len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 9)) : 8'd4;
            wdata[31:0] = power_word();
        end
        send_command(func, 8'($urandom), len, key, wdata);
    endtask

    initial begin
        cmd.valid      = 1'b0;
        cmd.func       = '0;
        cmd.tag        = '0;
        cmd.length     = '0;
        cmd.key_name   = '0;
        cmd.write_data = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        quiet_tail     = 1'b0;
        hold_off       = 1'b0;
        sent           = 0;
        i_rst_n        = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every command, the extremes and special cases.
        send_command(FUNC_BUF_ADDR, 8'h00, 8'h00, 32'h0, 64'h0);
        send_command(FUNC_READ, 8'hFF, 8'h00, 32'h234B4559, '1);          // count key
        send_command(FUNC_READ_ALT, 8'h5A, 8'hFF, 32'h434C4B48, 64'h0);   // long read
        send_command(FUNC_READ, 8'h01, 8'h00, 32'h4D425345, 64'h0);       // power: no read
        send_command(FUNC_READ, 8'h02, 8'h00, 32'h4E45534E, 64'h0);       // notify: no read
        send_command(FUNC_READ, 8'h03, 8'h00, 32'hFFFFFFFF, 64'h0);       // not found
        send_command(FUNC_WRITE, 8'h04, 8'h04, 32'h234B4559, 64'h0);      // count: no write
        send_command(FUNC_WRITE, 8'h05, 8'h08, 32'h4D425345, {32'h0, PW_OFFW}); // bad arg
        send_command(FUNC_WRITE, 8'h06, 8'h04, 32'h4D425345, {32'hFFFFFFFF, PW_SUSP});
        send_command(FUNC_WRITE, 8'h07, 8'h04, 32'h4D425345, {32'h0, PW_REST});
        send_command(FUNC_WRITE, 8'h08, 8'h04, 32'h4D425345, {32'h0, PW_PANB});
        send_command(FUNC_WRITE, 8'h09, 8'h04, 32'h4D425345, {32'h0, PW_PANE});
        send_command(FUNC_WRITE, 8'h0A, 8'h04, 32'h4D425345, '1);         // bad power word
        send_command(FUNC_WRITE, 8'h0B, 8'hFF, 32'h0, '1);                // new key, truncated
        send_command(FUNC_READ, 8'h0C, 8'h00, 32'h0, 64'h0);
        send_command(FUNC_WRITE, 8'h0D, 8'h03, 32'h4E45534E, 64'h00ABCDEF);
        send_command(FUNC_WRITE, 8'h0E, 8'h00, 32'hFFFFFFFF, 64'h0);
        send_command(FUNC_READ, 8'h0F, 8'h00, 32'hFFFFFFFF, 64'h0);
        send_command(FUNC_BY_INDEX, 8'h10, 8'h00, 32'd0, 64'h0);
        send_command(FUNC_BY_INDEX, 8'h11, 8'h00, 32'd7, 64'h0);
        send_command(FUNC_BY_INDEX, 8'h12, 8'h00, 32'hFFFFFFFF, 64'h0);   // out of range
        send_command(FUNC_INFO, 8'h13, 8'h00, 32'h434C4B48, 64'h0);
        send_command(FUNC_INFO, 8'h14, 8'h00, 32'h12345678, 64'h0);
        send_command(8'hFF, 8'h15, 8'hFF, '1, '1);                        // bad command
        write_buffer_address('1);

        // Random phases; fill the table in the second one to reach table full.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) hold_off = 1'b1;
            if (ph == 3) quiet_tail = 1'b1;
            repeat (215) random_command(ph == 1 ? 5 : 1);
            write_buffer_address(ph == 0 ? 64'h0 : {$urandom, $urandom});
        end

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("covered %0d commands and %0d checked results over %0d cycles,",
                 sent, results, cycles);
        $display("including power words, table full, truncation and register updates");
        if (errors == 0 && pending == 0) begin
            $display("key_value_mailbox_controller regression: pass");
        end else begin
            $display("key_value_mailbox_controller regression: fail");
        end
        $finish;
    end
endmodule
